// ===== src/tbc_pkg.sv =====
package tbc_pkg;

  localparam int CW  = 24;              // coordinate width
  localparam int NV  = 4;               // v0, v1, v2, p
  localparam int NA  = 3;               // x, y, z
  localparam int NP  = 4;               // cross pairs: normal plus three weights
  localparam int DW  = CW + 1;          // difference
  localparam int PW  = 2 * DW;          // cross partial product
  localparam int XW  = PW + 1;          // cross component
  localparam int LW  = (XW + 1) / 2;    // low split of a cross component
  localparam int HW  = XW - LW;         // high split
  localparam int MW  = 2 * XW;          // dot partial product
  localparam int SW  = MW + 2;          // dot sum
  localparam int OFB = 16;              // output fraction bits
  localparam int BW  = 32;              // weight width, also quotient bits
  localparam int NW  = SW + OFB;        // scaled dividend
  localparam int RW  = SW + BW;         // divider compare width
  localparam int TDI = ((NV * NA * CW + 7) / 8) * 8;
  localparam int TDO = ((NA * BW + 7) / 8) * 8;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] dw_t;
  typedef logic signed [PW-1:0] pw_t;
  typedef logic signed [XW-1:0] xw_t;
  typedef logic signed [MW-1:0] mw_t;
  typedef logic signed [SW-1:0] sw_t;
  typedef logic [SW-1:0]        mag_t;
  typedef logic signed [BW-1:0] bary_t;

  // split product of two cross components, summed one stage later
  typedef struct packed {
    logic signed [2*HW-1:0]    hh;
    logic signed [HW+LW:0]     hl;
    logic signed [HW+LW:0]     lh;
    logic [2*LW-1:0]           ll;
  } part_t;

  typedef struct packed {
    logic neg;
    logic sat;
    logic degen;
  } wflag_t;

  function automatic dw_t vdiff(coord_t a, coord_t b);
    return DW'(a) - DW'(b);
  endfunction

  function automatic part_t part_mul(xw_t a, xw_t b);
    logic signed [HW-1:0] ah;
    logic signed [HW-1:0] bh;
    logic signed [LW:0]   al;
    logic signed [LW:0]   bl;
    part_t r;
    ah   = a[XW-1:LW];
    bh   = b[XW-1:LW];
    al   = $signed({1'b0, a[LW-1:0]});
    bl   = $signed({1'b0, b[LW-1:0]});
    r.hh = (2*HW)'(ah) * (2*HW)'(bh);
    r.hl = (HW+LW+1)'(ah) * (HW+LW+1)'(bl);
    r.lh = (HW+LW+1)'(al) * (HW+LW+1)'(bh);
    r.ll = (2*LW)'(a[LW-1:0]) * (2*LW)'(b[LW-1:0]);
    return r;
  endfunction

  function automatic mw_t part_sum(part_t p);
    mw_t hh;
    mw_t mid;
    mw_t ll;
    hh  = MW'(p.hh) <<< (2*LW);
    mid = (MW'(p.hl) + MW'(p.lh)) <<< LW;
    ll  = $signed(MW'(p.ll));
    return hh + mid + ll;
  endfunction

endpackage

// ===== src/tbc_front.sv =====
module tbc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  tbc_pkg::coord_t pt_i [tbc_pkg::NV][tbc_pkg::NA],
  output logic           valid_o,
  output tbc_pkg::xw_t   cr_o [tbc_pkg::NP][tbc_pkg::NA]
);
  import tbc_pkg::*;

  dw_t  a_q  [NP][NA];
  dw_t  b_q  [NP][NA];
  pw_t  p0_q [NP][NA];
  pw_t  p1_q [NP][NA];
  xw_t  cr_q [NP][NA];
  logic [2:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // edges and offsets, paired for the four cross products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < NA; j++) begin
        a_q[0][j] <= vdiff(pt_i[2][j], pt_i[1][j]);
        b_q[0][j] <= vdiff(pt_i[0][j], pt_i[2][j]);
        a_q[1][j] <= vdiff(pt_i[2][j], pt_i[1][j]);
        b_q[1][j] <= vdiff(pt_i[3][j], pt_i[2][j]);
        a_q[2][j] <= vdiff(pt_i[0][j], pt_i[2][j]);
        b_q[2][j] <= vdiff(pt_i[3][j], pt_i[0][j]);
        a_q[3][j] <= vdiff(pt_i[1][j], pt_i[0][j]);
        b_q[3][j] <= vdiff(pt_i[3][j], pt_i[1][j]);
      end
    end
  end

  for (genvar k = 0; k < NP; k++) begin : g_pair
    for (genvar i = 0; i < NA; i++) begin : g_comp
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          p0_q[k][i] <= PW'(a_q[k][(i+1)%NA]) * PW'(b_q[k][(i+2)%NA]);
          p1_q[k][i] <= PW'(a_q[k][(i+2)%NA]) * PW'(b_q[k][(i+1)%NA]);
          cr_q[k][i] <= XW'(p0_q[k][i]) - XW'(p1_q[k][i]);
        end
      end
    end
  end

  assign valid_o = vld_q[2];
  assign cr_o    = cr_q;

endmodule

// ===== src/tbc_dot.sv =====
module tbc_dot (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  tbc_pkg::xw_t    cr_i [tbc_pkg::NP][tbc_pkg::NA],
  output logic            valid_o,
  output tbc_pkg::mag_t   den_o,
  output tbc_pkg::mag_t   mag_o [tbc_pkg::NA],
  output tbc_pkg::wflag_t flag_o [tbc_pkg::NA]
);
  import tbc_pkg::*;

  part_t  part_q [NP][NA];
  mw_t    prod_q [NP][NA];
  sw_t    dot_q  [NP];
  mag_t   den_q;
  mag_t   mag_q  [NA];
  wflag_t flag_q [NA];
  logic [3:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // pair 0 is the normal: its dot with itself is the denominator
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NP; k++) begin
        for (int i = 0; i < NA; i++) begin
          part_q[k][i] <= part_mul(cr_i[k][i], cr_i[0][i]);
          prod_q[k][i] <= part_sum(part_q[k][i]);
        end
        dot_q[k] <= SW'(prod_q[k][0]) + SW'(prod_q[k][1]) + SW'(prod_q[k][2]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q <= mag_t'(dot_q[0]);
      for (int w = 0; w < NA; w++) begin
        mag_t m;
        m = dot_q[w+1][SW-1] ? mag_t'(-dot_q[w+1]) : mag_t'(dot_q[w+1]);
        mag_q[w]        <= m;
        flag_q[w].neg   <= dot_q[w+1][SW-1];
        // quotient would reach 2^BW or more
        flag_q[w].sat   <= NW'(m) >= (NW'(dot_q[0]) << OFB);
        flag_q[w].degen <= dot_q[0] == '0;
      end
    end
  end

  assign valid_o = vld_q[3];
  assign den_o   = den_q;
  assign mag_o   = mag_q;
  assign flag_o  = flag_q;

endmodule

// ===== src/tbc_div.sv =====
module tbc_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  tbc_pkg::mag_t   den_i,
  input  tbc_pkg::mag_t   mag_i,
  input  tbc_pkg::wflag_t flag_i,
  output logic            valid_o,
  output tbc_pkg::bary_t  bary_o,
  output logic            degen_o
);
  import tbc_pkg::*;

  localparam logic [BW-1:0] MaxPos = {1'b0, {(BW-1){1'b1}}};
  localparam logic [BW-1:0] MinNeg = {1'b1, {(BW-1){1'b0}}};

  logic [NW-1:0] rem_q  [BW+1];
  mag_t          den_q  [BW+1];
  logic [BW-1:0] quo_q  [BW+1];
  wflag_t        flag_q [BW+1];
  logic [BW+1:0] vld_q;
  bary_t         bary_q;
  logic          degen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[BW:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= NW'(mag_i) << OFB;
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      flag_q[0] <= flag_i;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 0; s < BW; s++) begin : g_step
    localparam int K = BW - 1 - s;
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = RW'(den_q[s]) << K;
    assign ge  = RW'(rem_q[s]) >= dsh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= ge ? NW'(RW'(rem_q[s]) - dsh) : rem_q[s];
        den_q[s+1]  <= den_q[s];
        quo_q[s+1]  <= quo_q[s] | (BW'(ge) << K);
        flag_q[s+1] <= flag_q[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      degen_q <= flag_q[BW].degen;
      if (flag_q[BW].degen) begin
        bary_q <= '0;
      end else if (flag_q[BW].neg) begin
        bary_q <= (flag_q[BW].sat || quo_q[BW] > MinNeg) ? bary_t'(MinNeg)
                                                         : bary_t'(-quo_q[BW]);
      end else begin
        bary_q <= (flag_q[BW].sat || quo_q[BW][BW-1]) ? bary_t'(MaxPos)
                                                      : bary_t'(quo_q[BW]);
      end
    end
  end

  assign valid_o = vld_q[BW+1];
  assign bary_o  = bary_q;
  assign degen_o = degen_q;

endmodule

// ===== src/triangle_barycentric_coords_unit.sv =====
// Barycentric weights of a query point against a 3D triangle.
//
// Input stream (s_axis): one beat carries v0, v1, v2 and p, twelve signed
// Q12.12 coordinates packed in tdata. Output stream (m_axis): one beat per
// input beat, in order, with the three Q15.16 weights in tdata and the
// degenerate flag in tuser. Zero-area triangles give zero weights and
// tuser high; weights outside the Q15.16 range saturate.
//
// Throughput: one beat per clock while the receiver does not stall. Each beat
// passes 3 cross-product and 4 dot-product stages, then the 32-stage
// restoring divider (one quotient bit per stage).
//
// Flow control: the whole pipeline advances on one enable, high when the
// output register is empty or being taken. A stalled receiver freezes every
// stage in place, so nothing is dropped or repeated; s_axis_tready mirrors
// the enable.
//
// Reset clears only the stage valid bits; no beat is in flight after it.
module triangle_barycentric_coords_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, p_x, p_y, p_z
  input  logic [tbc_pkg::TDI-1:0] s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // bary_0, bary_1, bary_2
  output logic [tbc_pkg::TDO-1:0] m_axis_tdata,
  // degenerate
  output logic                   m_axis_tuser
);
  import tbc_pkg::*;

  logic   en;
  coord_t pt [NV][NA];
  logic   front_vld;
  xw_t    cr [NP][NA];
  logic   dot_vld;
  mag_t   den;
  mag_t   mag [NA];
  wflag_t flag [NA];
  logic   [NA-1:0] div_vld;
  bary_t  bary [NA];
  logic   [NA-1:0] degen;

  // global stall: the last divider register is the output register
  assign en            = m_axis_tready | ~m_axis_tvalid;
  assign s_axis_tready = en;

  always_comb begin
    for (int i = 0; i < NV; i++) begin
      for (int j = 0; j < NA; j++) begin
        pt[i][j] = s_axis_tdata[(i*NA+j)*CW +: CW];
      end
    end
  end

  tbc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .pt_i    (pt),
    .valid_o (front_vld),
    .cr_o    (cr)
  );

  tbc_dot u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_vld),
    .cr_i    (cr),
    .valid_o (dot_vld),
    .den_o   (den),
    .mag_o   (mag),
    .flag_o  (flag)
  );

  for (genvar w = 0; w < NA; w++) begin : g_div
    tbc_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dot_vld),
      .den_i   (den),
      .mag_i   (mag[w]),
      .flag_i  (flag[w]),
      .valid_o (div_vld[w]),
      .bary_o  (bary[w]),
      .degen_o (degen[w])
    );
  end

  // all three dividers run in lockstep
  assign m_axis_tvalid = div_vld[0] & div_vld[1] & div_vld[2];
  assign m_axis_tuser  = degen[0] & degen[1] & degen[2];

  always_comb begin
    m_axis_tdata = '0;
    for (int w = 0; w < NA; w++) begin
      m_axis_tdata[w*BW +: BW] = bary[w];
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tbc_pkg::*;

  typedef logic signed [191:0] wide_t;
  typedef struct packed {
    wide_t x;
    wide_t y;
    wide_t z;
  } wvec_t;
  typedef struct packed {
    bary_t b0;
    bary_t b1;
    bary_t b2;
    logic  degen;
  } weights_t;

  localparam int QUIET_START = 400;   // no idling from here ...
  localparam int QUIET_END   = 900;   // ... to here
  localparam int HOLD_AT     = 1500;  // receiver holds off from this cycle
  localparam int HOLD_LEN    = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [TDI-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [TDO-1:0] m_axis_tdata;
  logic m_axis_tuser;

  logic [TDI-1:0] pending_tris[$];
  weights_t       weights_due[$];
  int cycle = 0;
  int hold_cnt = 0;
  int errors = 0;

  always #2 clk_i = ~clk_i;

  triangle_barycentric_coords_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // ---------------- barycentric predictor, exact wide arithmetic ----------------
  function automatic wvec_t coord_vec(logic [TDI-1:0] d, int k);
    wvec_t r;
    r.x = wide_t'($signed(d[(3*k)*CW +: CW]));
    r.y = wide_t'($signed(d[(3*k+1)*CW +: CW]));
    r.z = wide_t'($signed(d[(3*k+2)*CW +: CW]));
    return r;
  endfunction

  function automatic wvec_t vsub(wvec_t a, wvec_t b);
    wvec_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic wvec_t vcross(wvec_t a, wvec_t b);
    wvec_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  function automatic wide_t vdot(wvec_t a, wvec_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  // num * 2^16 / den truncated toward zero, saturated to Q15.16
  function automatic bary_t scaled_ratio(wide_t num, wide_t den);
    logic  neg;
    wide_t mag;
    wide_t q;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (mag <<< OFB) / den;
    if (neg) return (q > 64'sh80000000) ? 32'h80000000 : bary_t'(-q);
    return (q > 64'sh7FFFFFFF) ? 32'h7FFFFFFF : bary_t'(q);
  endfunction

  function automatic weights_t predict_weights(logic [TDI-1:0] d);
    wvec_t v0, v1, v2, p, e1, e2, e3, c;
    wide_t den;
    weights_t w;
    v0 = coord_vec(d, 0);
    v1 = coord_vec(d, 1);
    v2 = coord_vec(d, 2);
    p  = coord_vec(d, 3);
    e1 = vsub(v2, v1);
    e2 = vsub(v0, v2);
    e3 = vsub(v1, v0);
    c  = vcross(e1, e2);
    den = vdot(c, c);
    w = '0;
    if (den == 0) begin
      w.degen = 1'b1;
      return w;
    end
    w.b0 = scaled_ratio(vdot(vcross(e1, vsub(p, v2)), c), den);
    w.b1 = scaled_ratio(vdot(vcross(e2, vsub(p, v0)), c), den);
    w.b2 = scaled_ratio(vdot(vcross(e3, vsub(p, v1)), c), den);
    return w;
  endfunction

  // ---------------- stimulus builders ----------------
  function automatic logic [TDI-1:0] pack_tri(coord_t c[12]);
    logic [TDI-1:0] d;
    d = '0;
    for (int i = 0; i < 12; i++) d[i*CW +: CW] = c[i];
    return d;
  endfunction

  function automatic coord_t rnd_coord(int span);
    coord_t r;
    if (span >= CW) r = coord_t'($urandom);
    else r = coord_t'($signed($urandom_range(2 * (1 << span))) - (1 << span));
    return r;
  endfunction

  task automatic queue_random();
    coord_t c[12];
    int kind;
    int span;
    kind = $urandom_range(99);
    span = ($urandom_range(1)) ? CW : $urandom_range(14, 2);
    for (int i = 0; i < 12; i++) c[i] = rnd_coord(span);
    if (kind < 8) begin
      // collinear: v2 = v0 + 2*(v1-v0), small so it stays in range
      for (int a = 0; a < 3; a++) begin
        c[a]   = rnd_coord(20);
        c[3+a] = rnd_coord(20);
        c[6+a] = coord_t'(2 * c[3+a] - c[a]);
      end
    end else if (kind < 12) begin
      for (int a = 0; a < 3; a++) c[3+a] = c[a];  // repeated vertex
    end else if (kind < 25) begin
      // tiny triangle, far point: weights saturate
      for (int a = 0; a < 3; a++) begin
        c[3+a] = c[a] + rnd_coord(2);
        c[6+a] = c[a] + rnd_coord(2);
        c[9+a] = rnd_coord(CW);
      end
    end
    pending_tris.push_back(pack_tri(c));
  endtask

  task automatic queue_directed();
    coord_t c[12];
    coord_t mx, mn;
    mx = 24'sh7FFFFF;
    mn = 24'sh800000;
    for (int i = 0; i < 12; i++) c[i] = '0;
    pending_tris.push_back(pack_tri(c));                       // all zero: degenerate
    for (int i = 0; i < 12; i++) c[i] = mx;
    pending_tris.push_back(pack_tri(c));                       // all max: degenerate
    for (int i = 0; i < 12; i++) c[i] = mn;
    pending_tris.push_back(pack_tri(c));
    // unit right triangle in xy, point at each vertex and centroid
    c = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0, 0, 0, 0};
    pending_tris.push_back(pack_tri(c));
    c[9] = 4096;
    pending_tris.push_back(pack_tri(c));
    c[9] = 0; c[10] = 4096;
    pending_tris.push_back(pack_tri(c));
    c[9] = 1365; c[10] = 1365;
    pending_tris.push_back(pack_tri(c));
    c[9] = mx; c[10] = mn; c[11] = mx;                           // far outside
    pending_tris.push_back(pack_tri(c));
    // extreme vertices
    c = '{mn, mn, mn, mx, mn, mn, mn, mx, mx, mx, mx, mx};
    pending_tris.push_back(pack_tri(c));
    c = '{mx, mx, mn, mn, mx, mx, mx, mn, mx, mn, mn, mn};
    pending_tris.push_back(pack_tri(c));
    // smallest nonzero area, point at far corner: saturates both ways
    c = '{0, 0, 0, 1, 0, 0, 0, 1, 0, mx, mx, mx};
    pending_tris.push_back(pack_tri(c));
    c = '{0, 0, 0, 1, 0, 0, 0, 1, 0, mn, mn, mn};
    pending_tris.push_back(pack_tri(c));
    c = '{0, 0, 0, 0, 1, 0, 0, 0, 1, mn, mx, mn};                // yz plane
    pending_tris.push_back(pack_tri(c));
    // alternating bit patterns
    for (int i = 0; i < 12; i++) c[i] = (i % 2) ? 24'sh555555 : 24'shAAAAAA;
    pending_tris.push_back(pack_tri(c));
    for (int i = 0; i < 12; i++) c[i] = (i % 3) ? 24'shAAAAAA : 24'sh555555;
    pending_tris.push_back(pack_tri(c));
  endtask

  // ---------------- driver ----------------
  function automatic bit side_idles();
    if (cycle >= QUIET_START && cycle < QUIET_END) return 1'b0;
    return $urandom_range(99) < 12;
  endfunction

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        weights_due.push_back(predict_weights(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_tris.size() > 0 && !side_idles()) begin
          s_axis_tdata  <= pending_tris.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver hold-off counter ----------------
  // long hold-off so the pipeline fills and backs up the input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cycle == HOLD_AT) hold_cnt <= HOLD_LEN;
      else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    end
  end

  // ---------------- receiver and checker ----------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch @%0d %s: got %h want %h", cycle, what, got, want);
  endtask

  always @(posedge clk_i) begin
    weights_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (weights_due.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata[31:0], '0);
        end else begin
          want = weights_due.pop_front();
          if (m_axis_tdata[0 +: BW] !== want.b0)
            report_mismatch("bary_0", m_axis_tdata[0 +: BW], want.b0);
          if (m_axis_tdata[BW +: BW] !== want.b1)
            report_mismatch("bary_1", m_axis_tdata[BW +: BW], want.b1);
          if (m_axis_tdata[2*BW +: BW] !== want.b2)
            report_mismatch("bary_2", m_axis_tdata[2*BW +: BW], want.b2);
          if (m_axis_tuser !== want.degen)
            report_mismatch("degenerate", {31'b0, m_axis_tuser}, {31'b0, want.degen});
        end
      end
      m_axis_tready <= (hold_cnt > 1 || cycle == HOLD_AT) ? 1'b0 : !side_idles();
    end
  end

  // ---------------- sequence ----------------
  initial begin
    queue_directed();
    for (int i = 0; i < 1950; i++) queue_random();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_tris.size() == 0);
    @(posedge clk_i);
    while (s_axis_tvalid) @(posedge clk_i);
    @(posedge clk_i);
    while (weights_due.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("testbench: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
src/tbc_pkg.sv
src/tbc_front.sv
src/tbc_dot.sv
src/tbc_div.sv
src/triangle_barycentric_coords_unit.sv
tb/testbench.sv
